### rtl/core/cwsj_pkg.sv
// Shared types, constants and codes for the checkweigher stability judge.
package cwsj_pkg;

  localparam int unsigned STABLE_COUNT_DEF = 32;

  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned NOMINAL_W  = 31;
  localparam int unsigned BAND_W     = 27;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;

  // floor(x / 5) == (x * RECIP5) >> 34 for any 32-bit x
  localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP5_SHIFT = 34;

  localparam logic signed [WEIGHT_W-1:0] FLOOR_KG_MG = 32'sd10000;
  localparam logic signed [WEIGHT_W-1:0] FLOOR_G_MG  = 32'sd2000;
  localparam logic [BAND_W-1:0]          ZERO_NOM_BAND_MG = 27'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_IS_KG = 2'd0,
    CFG_NOMINAL    = 2'd1,
    CFG_TOLERANCE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JDG_NONE = 2'd0,
    JDG_PASS = 2'd1,
    JDG_FAIL = 2'd2
  } judge_t;

  // settings derived from the config registers, ready for the judge stage
  typedef struct packed {
    logic                      unit_is_kg;
    logic [BAND_W-1:0]         band;
    logic signed [WEIGHT_W-1:0] lo;
    logic signed [WEIGHT_W:0]   hi;
  } cwsj_cfg_t;

endpackage

### rtl/core/cwsj_cfg.sv
// Config registers and the derived band and pass window.
module cwsj_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cwsj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwsj_pkg::NOMINAL_W-1:0]     cfg_wdata,
  output cwsj_pkg::cwsj_cfg_t                cfg_o
);
  import cwsj_pkg::*;

  localparam int unsigned PROD_W = (NOMINAL_W - 2) + 32;

  logic                 unit_is_kg_r;
  logic [NOMINAL_W-1:0] nominal_r;
  logic [NOMINAL_W-1:0] tolerance_r;
  cwsj_cfg_t            der_r;
  cwsj_cfg_t            der_nxt;
  logic [PROD_W-1:0]    prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_is_kg_r <= 1'b0;
      nominal_r    <= '0;
      tolerance_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_UNIT_IS_KG: unit_is_kg_r <= cfg_wdata[0];
        CFG_NOMINAL:    nominal_r    <= cfg_wdata;
        CFG_TOLERANCE:  tolerance_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // nominal / 20 = (nominal >> 2) / 5
  assign prod = PROD_W'(nominal_r[NOMINAL_W-1:2]) * PROD_W'(RECIP5);

  always_comb begin
    der_nxt.unit_is_kg = unit_is_kg_r;
    if (!unit_is_kg_r && (nominal_r == '0))
      der_nxt.band = ZERO_NOM_BAND_MG;
    else
      der_nxt.band = prod[RECIP5_SHIFT +: BAND_W];
    der_nxt.lo = $signed({1'b0, nominal_r}) - $signed({1'b0, tolerance_r});
    der_nxt.hi = $signed({2'b0, nominal_r}) + $signed({2'b0, tolerance_r});
  end

  // derived settings register: a cfg write lands in the config registers first, then here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      der_r.unit_is_kg <= 1'b0;
      der_r.band       <= ZERO_NOM_BAND_MG;
      der_r.lo         <= '0;
      der_r.hi         <= '0;
    end else begin
      der_r <= der_nxt;
    end
  end

  assign cfg_o = der_r;

endmodule

### rtl/core/cwsj_judge.sv
// Stability counter, judgement state and the result register.
module cwsj_judge #(
  parameter int unsigned STABLE_COUNT = cwsj_pkg::STABLE_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cwsj_pkg::cwsj_cfg_t                cfg_i,
  input  logic                               in_valid,
  input  logic signed [cwsj_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                               in_fresh,
  output logic                               take,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cwsj_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import cwsj_pkg::*;

  localparam int unsigned RUN_W = $clog2(STABLE_COUNT + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(STABLE_COUNT);
  localparam int unsigned MUL_W = WEIGHT_W + 4;

  logic signed [WEIGHT_W-1:0] prev_r, prev_nxt;
  logic signed [WEIGHT_W-1:0] latched_r, latched_nxt;
  logic [RUN_W-1:0]           run_r, run_nxt;
  judge_t                     status_r, status_nxt;
  logic                       out_valid_r;
  logic [OUT_DATA_W-1:0]      out_data_r, out_data_nxt;

  logic signed [WEIGHT_W:0]   diff;
  logic [WEIGHT_W:0]          abs_diff;
  logic                       in_band;
  logic                       prev_above;
  logic                       stable;
  logic signed [WEIGHT_W-1:0] floor_mg;
  logic                       in_window;
  logic signed [MUL_W-1:0]    w_ext, l_ext, w10, l9, l11;
  logic                       drifted;

  assign take = in_valid && (!out_valid_r || out_tready);

  always_comb begin
    diff       = {in_weight[WEIGHT_W-1], in_weight} - {prev_r[WEIGHT_W-1], prev_r};
    abs_diff   = diff[WEIGHT_W] ? unsigned'(-diff) : unsigned'(diff);
    in_band    = abs_diff <= (WEIGHT_W+1)'(cfg_i.band);
    prev_above = prev_r > $signed(WEIGHT_W'(cfg_i.band));

    run_nxt  = run_r;
    prev_nxt = prev_r;
    if (in_fresh) begin
      if (in_band) begin
        if (prev_above && (run_r < RUN_MAX))
          run_nxt = run_r + 1'b1;
      end else begin
        run_nxt = '0;
      end
      prev_nxt = in_weight;
    end
    stable = run_nxt >= RUN_MAX;

    floor_mg  = cfg_i.unit_is_kg ? FLOOR_KG_MG : FLOOR_G_MG;
    in_window = (in_weight >= cfg_i.lo) &&
                ($signed({in_weight[WEIGHT_W-1], in_weight}) <= cfg_i.hi);

    // exact 90% / 110% drift test
    w_ext   = MUL_W'(in_weight);
    l_ext   = MUL_W'(latched_r);
    w10     = (w_ext <<< 3) + (w_ext <<< 1);
    l9      = (l_ext <<< 3) + l_ext;
    l11     = (l_ext <<< 3) + (l_ext <<< 1) + l_ext;
    drifted = (w10 <= l9) || (w10 >= l11);

    status_nxt  = status_r;
    latched_nxt = latched_r;
    if (stable) begin
      if (in_weight <= floor_mg) begin
        status_nxt  = JDG_NONE;
        latched_nxt = '0;
      end else if (status_r == JDG_NONE) begin
        status_nxt  = in_window ? JDG_PASS : JDG_FAIL;
        latched_nxt = in_weight;
      end
    end else if ((latched_r != '0) && drifted) begin
      status_nxt  = JDG_NONE;
      latched_nxt = '0;
    end

    out_data_nxt = {(OUT_DATA_W - WEIGHT_W - 3)'(0), stable, status_nxt, in_weight};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      latched_r <= '0;
      run_r     <= '0;
      status_r  <= JDG_NONE;
    end else if (take) begin
      prev_r    <= prev_nxt;
      latched_r <= latched_nxt;
      run_r     <= run_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= RUN_MAX)
    else $error("stable run counter past its limit");

  a_latch_tracks_status: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == JDG_NONE) == (latched_r == '0))
    else $error("latched weight and status out of step");

  a_stale_keeps_prev: assert property (@(posedge clk) disable iff (!rst_n)
    take && !in_fresh |=> $stable(prev_r) && $stable(run_r))
    else $error("non-fresh word moved the stability state");

  a_idle_keeps_status: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(status_r) && $stable(latched_r))
    else $error("judgement changed without a word");

endmodule

### rtl/core/checkweigher_stability_judge_unit.sv
// Top level of the checkweigher stability judge: input register, config, judge stage.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tdata: weight_mg[31:0]; tuser: fresh_sample
//  out_    | out | out_tvalid/out_tready| tdata: weight_out_mg, judgement, is_stable
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata (31 bits)
//
// One word per cycle with out_tready high; a word passes the input, then result register.
// The judge stage updates all state on each accepted word, so back-to-back words chain.
// out_tready low holds the result register, then the input register, then in_tready.
// rst_n is synchronous; cfg writes reach band, pass window via config, then derived regs.
module checkweigher_stability_judge_unit #(
  parameter int unsigned STABLE_COUNT = cwsj_pkg::STABLE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cwsj_pkg::WEIGHT_W-1:0]     in_tdata,   // [31:0] weight_mg
  input  logic                              in_tuser,   // [0] fresh_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] weight_out_mg, [33:32] judgement, [34] is_stable, [39:35] zero
  output logic [cwsj_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [cwsj_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cwsj_pkg::NOMINAL_W-1:0]    cfg_wdata
);
  import cwsj_pkg::*;

  logic                       in_valid_r;
  logic signed [WEIGHT_W-1:0] in_weight_r;
  logic                       in_fresh_r;
  logic                       take;
  cwsj_cfg_t                  cfg;

  assign in_tready = !in_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_weight_r <= $signed(in_tdata);
      in_fresh_r  <= in_tuser;
    end
  end

  cwsj_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  cwsj_judge #(
    .STABLE_COUNT (STABLE_COUNT)
  ) u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .in_valid   (in_valid_r),
    .in_weight  (in_weight_r),
    .in_fresh   (in_fresh_r),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### tb/checkweigher_stability_judge_unit_tb.sv
// Self-checking testbench for the checkweigher stability judge unit.
module checkweigher_stability_judge_unit_tb;
  import cwsj_pkg::*;

  localparam int STABLE_RUN = STABLE_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 200;
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;

  typedef struct {
    logic [WEIGHT_W-1:0] weight;
    judge_t              jdg;
    logic                stable;
  } reading_t;

  // Tracks the judge state word by word and holds the readings still due on out_.
  class judge_scoreboard;
    logic     kg;
    longint   nom_mg;
    longint   tol_mg;
    longint   prev_w;
    longint   latched_w;
    int       run;
    judge_t   status;
    reading_t expected_readings[$];
    int       errors;

    function new();
      kg = 1'b0;
      nom_mg = 0;
      tol_mg = 0;
      prev_w = 0;
      latched_w = 0;
      run = 0;
      status = JDG_NONE;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [NOMINAL_W-1:0] v);
      case (idx)
        CFG_UNIT_IS_KG: kg = v[0];
        CFG_NOMINAL:    nom_mg = longint'(v);
        CFG_TOLERANCE:  tol_mg = longint'(v);
        default: ;
      endcase
    endfunction

    function longint band_mg();
      if (!kg && nom_mg == 0) return 1000;
      return nom_mg / 20;
    endfunction

    function longint floor_mg();
      return kg ? 10000 : 2000;
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction

    function void note_poll(logic signed [WEIGHT_W-1:0] w_in, logic fresh);
      longint   w;
      longint   d;
      longint   band;
      logic     stable;
      reading_t res;
      w = longint'(w_in);
      if (fresh) begin
        band = band_mg();
        d = w - prev_w;
        if (d < 0) d = -d;
        if (d <= band) begin
          // only counts when the previous reading sat above the band
          if (prev_w > band && run < STABLE_RUN) run++;
        end else begin
          run = 0;
        end
        prev_w = w;
      end
      stable = (run >= STABLE_RUN);
      if (stable) begin
        if (w <= floor_mg()) begin
          status = JDG_NONE;
          latched_w = 0;
        end else if (status == JDG_NONE) begin
          status = (w >= nom_mg - tol_mg && w <= nom_mg + tol_mg) ? JDG_PASS : JDG_FAIL;
          latched_w = w;
        end
      end else if (latched_w != 0) begin
        if (10 * w <= 9 * latched_w || 10 * w >= 11 * latched_w) begin
          status = JDG_NONE;
          latched_w = 0;
        end
      end
      res.weight = w_in;
      res.jdg = status;
      res.stable = stable;
      expected_readings.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      reading_t exp;
      if (expected_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result word %h", word);
        return;
      end
      exp = expected_readings.pop_front();
      if (word[31:0] !== exp.weight || word[33:32] !== exp.jdg || word[34] !== exp.stable) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: weight exp %h got %h, judgement exp %0d got %0d, stable exp %0b got %0b",
                   exp.weight, word[31:0], exp.jdg, word[33:32], exp.stable, word[34]);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [WEIGHT_W-1:0]    in_tdata = '0;   // [31:0] weight_mg
  logic                   in_tuser = 1'b0; // [0] fresh_sample
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [31:0] weight_out_mg, [33:32] judgement, [34] is_stable, [39:35] zero
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [NOMINAL_W-1:0]   cfg_wdata = '0;

  judge_scoreboard sb = new();
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   words_sent = 0;
  int   cycles = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;

  checkweigher_stability_judge_unit #(.STABLE_COUNT(STABLE_RUN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("checkweigher_stability_judge_unit: mismatch");
      $finish;
    end
  end

  // result side: check accepted words, random stalls, one long hold-off
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic logic signed [WEIGHT_W-1:0] to_weight(longint v);
    if (v > W_MAX) v = W_MAX;
    if (v < W_MIN) v = W_MIN;
    return v[31:0];
  endfunction

  function automatic longint rand_span(longint m);
    longint r;
    if (m > W_MAX) m = W_MAX;
    if (m < 0) m = 0;
    r = longint'($urandom_range(0, m[31:0]));
    return $urandom_range(0, 1) ? r : -r;
  endfunction

  task automatic send_word(input logic signed [WEIGHT_W-1:0] w, input logic fresh);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= fresh;
    do @(posedge clk); while (!in_tready);
    sb.note_poll(w, fresh);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_regs(input logic kg, input logic [NOMINAL_W-1:0] nom,
                          input logic [NOMINAL_W-1:0] tol);
    cfg_we <= 1'b1;
    cfg_index <= CFG_UNIT_IS_KG;
    cfg_wdata <= {30'd0, kg};
    @(posedge clk);
    cfg_index <= CFG_NOMINAL;
    cfg_wdata <= nom;
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_UNIT_IS_KG, {30'd0, kg});
    sb.set_reg(CFG_NOMINAL, nom);
    sb.set_reg(CFG_TOLERANCE, tol);
    // wait for band and pass window to settle through the config and derived registers
    repeat (3) @(posedge clk);
  endtask

  // a run of fresh readings around one target, mostly inside the band, with stale words mixed in
  task automatic settle_seq();
    longint band;
    longint tgt;
    longint last;
    longint w;
    int     n;
    int     k;
    int     r;
    band = sb.band_mg();
    case ($urandom_range(0, 6))
      0, 1: begin
        case ($urandom_range(0, 5))
          0: tgt = sb.nom_mg - sb.tol_mg - 1;
          1: tgt = sb.nom_mg - sb.tol_mg;
          2: tgt = sb.nom_mg;
          3: tgt = sb.nom_mg + sb.tol_mg;
          4: tgt = sb.nom_mg + sb.tol_mg + 1;
          default: tgt = sb.nom_mg + rand_span(2 * sb.tol_mg + band + 1);
        endcase
      end
      2: tgt = sb.floor_mg() + longint'($urandom_range(0, 2)) - 1;
      3: tgt = sb.prev_w;
      4: tgt = band + longint'($urandom_range(0, 2));
      5: tgt = longint'($urandom_range(0, 32'h7FFF_FFFF));
      default: tgt = longint'(signed'($urandom()));
    endcase
    tgt = longint'(to_weight(tgt));
    n = $urandom_range(20, 60);
    last = tgt;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        w = (last > tgt) ? last - band : last + band;
      else if (r < 11)
        w = last + band + 1 + longint'($urandom_range(0, 50));
      else
        w = tgt + rand_span(band / 2);
      w = longint'(to_weight(w));
      send_word(w[31:0], 1'b1);
      last = w;
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 2))
          0: send_word(to_weight(tgt), 1'b0);
          1: send_word(to_weight(sb.floor_mg() + rand_span(2)), 1'b0);
          default: send_word($urandom(), 1'b0);
        endcase
      end
    end
  endtask

  // break the run, then probe the 90% and 110% edges of the latched weight (random stale words if none is latched)
  task automatic drift_seq();
    longint band;
    longint l;
    longint w;
    int     n;
    int     k;
    band = sb.band_mg();
    if (sb.prev_w > 0)
      w = sb.prev_w - band - 1 - longint'($urandom_range(0, 1000));
    else
      w = sb.prev_w + band + 1 + longint'($urandom_range(0, 1000));
    send_word(to_weight(w), 1'b1);
    l = sb.latched_w;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      if (l == 0) begin
        send_word($urandom(), 1'b0);
      end else begin
        case ($urandom_range(0, 4))
          0: w = (9 * l) / 10;
          1: w = (9 * l) / 10 + 1;
          2: w = (11 * l + 9) / 10;
          3: w = (11 * l + 9) / 10 - 1;
          default: w = l;
        endcase
        send_word(to_weight(w), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  task automatic noise_seq();
    int n;
    int k;
    n = $urandom_range(1, 5);
    for (k = 0; k < n; k++) send_word($urandom(), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(input logic kg, input logic [NOMINAL_W-1:0] nom,
                           input logic [NOMINAL_W-1:0] tol, input int idle_pct,
                           input int stall, input logic pressure);
    int start;
    int kind;
    drain();
    set_regs(kg, nom, tol);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    if (pressure) hold_req = 1'b1;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) settle_seq();
      else if (kind < 85) drift_seq();
      else noise_seq();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and the band edge in gram mode, zero nominal
    set_regs(1'b0, 31'd0, 31'd0);
    send_word(32'h0000_0000, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h7FFF_FFFF, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(32'h5555_5555, 1'b1);
    send_word(32'hAAAA_AAAA, 1'b1);
    send_word(32'd2000, 1'b1);
    send_word(32'd2001, 1'b1);
    send_word(32'd1000, 1'b1);
    send_word(32'd1001, 1'b1);   // previous not above band: no count
    send_word(32'd1002, 1'b1);   // previous above band: counts
    send_word(32'd2002, 1'b1);   // exactly one band away
    send_word(32'd3003, 1'b1);   // one past the band

    run_phase(1'b0, 31'd0, 31'd0, 0, 0, 1'b1);
    run_phase(1'b0, 31'd250000, 31'd5000, 85, 0, 1'b0);
    run_phase(1'b1, 31'd0, 31'd0, 0, 85, 1'b0);
    run_phase(1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 10, 10, 1'b0);
    run_phase(1'b0, 31'h7FFF_FFFF, 31'd0, 0, 0, 1'b0);
    run_phase(1'b1, 31'd12000, 31'd500, 85, 0, 1'b0);
    run_phase(1'b0, 31'd3000, 31'h7FFF_FFFF, 0, 85, 1'b0);
    run_phase(1'($urandom_range(0, 1)), 31'($urandom_range(0, 32'h7FFF_FFFF)),
              31'($urandom_range(0, 32'h00FF_FFFF)), 10, 10, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("checkweigher_stability_judge_unit: match");
    else
      $display("checkweigher_stability_judge_unit: mismatch");
    $finish;
  end

endmodule

### checkweigher_stability_judge_unit.f
rtl/core/cwsj_pkg.sv
rtl/core/cwsj_cfg.sv
rtl/core/cwsj_judge.sv
rtl/core/checkweigher_stability_judge_unit.sv
tb/checkweigher_stability_judge_unit_tb.sv
